// ----- sv/tcc_pkg.sv -----
// Shared types and constants for the text console cursor controller.
`default_nettype none

package tcc_pkg;

    // Character codes with special handling.
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // Result kinds.
    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_DRAW   = 2'd1;
    localparam logic [1:0] KIND_SCROLL = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

    // Field widths.
    localparam int CHAR_W = 8;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 9;
    localparam int COLS_W = 9;
    localparam int ROWS_W = 10;
    localparam int PX_W   = 11;
    localparam int PY_W   = 13;

    // Datapath operations.
    typedef logic [1:0] t_op;
    localparam t_op OP_INPUT  = 2'd0;
    localparam t_op OP_SPACE  = 2'd1;
    localparam t_op OP_SCROLL = 2'd2;

    typedef struct packed {
        logic step;
        t_op  op;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tab;
        logic need_scroll;
        logic tab_cont;
    } t_dp_sts;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic [CHAR_W-1:0] cell_char;
        logic [PX_W-1:0]   pixel_x;
        logic [PY_W-1:0]   pixel_y;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/tcc_if.sv -----
// Handshake interfaces for the character input and result output channels.
`default_nettype none

interface tcc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tcc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [8:0]  cell_row;
    logic [7:0]  cell_col;
    logic [7:0]  cell_char;
    logic [10:0] pixel_x;
    logic [12:0] pixel_y;
    logic        last;

    modport source (output valid, output kind, output cell_row, output cell_col,
                    output cell_char, output pixel_x, output pixel_y, output last,
                    input ready);
    modport sink   (input valid, input kind, input cell_row, input cell_col,
                    input cell_char, input pixel_x, input pixel_y, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/text_console_cursor_control.sv -----
// Top level of the text console cursor controller.
// Each accepted character produces one or more result words in order on the output
// channel. Printable characters, newline and carriage return produce one word each and
// can be accepted back to back while the output word is taken; a step that moves the
// cursor past the last row adds a scroll word. A tab produces its marker word and then
// one word for each space (1 to TAB_STOP), plus a scroll word per scroll, and the input
// is held off until its last word is in the output register. The output register holds
// one word and is refilled in the cycle it is taken. Configuration writes take effect
// at once and must only be made while the block is idle.
`default_nettype none

module text_console_cursor_control #(
    parameter int CELL_WIDTH  = 8,
    parameter int CELL_HEIGHT = 16,
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 512,
    parameter int TAB_STOP    = 4,
    parameter int BORDER      = 4
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire [tcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [tcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tcc_char_if.sink                        i_char,
    tcc_result_if.source                    o_res
);

    tcc_pkg::t_dp_cmd w_cmd;
    tcc_pkg::t_dp_sts w_sts;
    tcc_pkg::t_result w_result;
    logic             w_out_valid;
    logic             w_in_ready;

    // Sequencing.
    tcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_char.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Cursor arithmetic and output word.
    tcc_dp #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT),
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_STOP    (TAB_STOP),
        .BORDER      (BORDER)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char_code (i_char.char_code),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_result    (w_result)
    );

    // Channel connections.
    assign i_char.ready    = w_in_ready;
    assign o_res.valid     = w_out_valid;
    assign o_res.kind      = w_result.kind;
    assign o_res.cell_row  = w_result.cell_row;
    assign o_res.cell_col  = w_result.cell_col;
    assign o_res.cell_char = w_result.cell_char;
    assign o_res.pixel_x   = w_result.pixel_x;
    assign o_res.pixel_y   = w_result.pixel_y;
    assign o_res.last      = w_result.last;

    // A character is only taken when the output register can take its first word.
    a_in_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char.ready |-> !(o_res.valid && !o_res.ready))
        else $error("input accepted while output word is stalled");

    // The words of one character follow each other without gaps.
    a_burst_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.last) |=> o_res.valid)
        else $error("gap inside a multi-word result");

    // Only glyph draws carry a pixel origin.
    a_pixel_only_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind != tcc_pkg::KIND_DRAW))
            |-> (o_res.pixel_x == '0 && o_res.pixel_y == '0))
        else $error("pixel origin on a non-draw word");

    // Scroll words carry no cell position.
    a_scroll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == tcc_pkg::KIND_SCROLL))
            |-> (o_res.cell_row == '0 && o_res.cell_col == '0))
        else $error("scroll word with a cell position");

endmodule

`default_nettype wire

// ----- sv/tcc_ctrl.sv -----
// Controller state machine: sequences the words of one character and owns output valid.
`default_nettype none

module tcc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  wire tcc_pkg::t_dp_sts i_sts,
    output tcc_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SPACE  = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_cont, n_cont;
    logic       r_out_valid, n_out_valid;
    logic       w_free;

    // The output register can take a word when empty or being emptied.
    assign w_free      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_free;
    assign o_out_valid = r_out_valid;

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        n_cont     = r_cont;
        o_cmd.step = 1'b0;
        o_cmd.op   = tcc_pkg::OP_INPUT;
        o_cmd.last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.op = tcc_pkg::OP_INPUT;
                if (i_in_valid && w_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.is_tab) begin
                        n_state = ST_SPACE;
                    end else if (i_sts.need_scroll) begin
                        n_state = ST_SCROLL;
                        n_cont  = 1'b0;
                    end else begin
                        o_cmd.last = 1'b1;
                    end
                end
            end
            ST_SPACE: begin
                o_cmd.op = tcc_pkg::OP_SPACE;
                if (w_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.need_scroll) begin
                        n_state = ST_SCROLL;
                        n_cont  = i_sts.tab_cont;
                    end else if (!i_sts.tab_cont) begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            ST_SCROLL: begin
                o_cmd.op = tcc_pkg::OP_SCROLL;
                if (w_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.last = !r_cont;
                    n_state    = r_cont ? ST_SPACE : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid follows each step and clears when the word is taken.
    always_comb begin
        if (o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cont      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cont      <= n_cont;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tcc_dp.sv -----
// Datapath: configuration, cursor registers, tab phase and the output word register.
`default_nettype none

module tcc_dp #(
    parameter int CELL_WIDTH  = 8,
    parameter int CELL_HEIGHT = 16,
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 512,
    parameter int TAB_STOP    = 4,
    parameter int BORDER      = 4
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire  [tcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [tcc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire  [tcc_pkg::CHAR_W-1:0]          i_char_code,
    input  wire tcc_pkg::t_dp_cmd               i_cmd,
    output tcc_pkg::t_dp_sts                    o_sts,
    output tcc_pkg::t_result                    o_result
);

    localparam int PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int MUL_W = 16;

    logic [tcc_pkg::COLS_W-1:0] r_columns;
    logic [tcc_pkg::ROWS_W-1:0] r_rows;
    logic [tcc_pkg::COL_W-1:0]  r_col, n_col;
    logic [tcc_pkg::ROW_W-1:0]  r_row;
    logic [tcc_pkg::ROWS_W-1:0] n_row;
    logic [PH_W-1:0]            r_phase, n_phase;
    tcc_pkg::t_result           r_res, n_res;

    logic [tcc_pkg::COLS_W-1:0] w_eff_cols;
    logic [tcc_pkg::ROWS_W-1:0] w_eff_rows;
    logic [tcc_pkg::COLS_W-1:0] w_col_inc;
    logic [tcc_pkg::ROWS_W-1:0] w_row_up;
    logic [PH_W-1:0]            w_ph_inc;
    logic                       w_wrap;
    logic                       w_is_lf, w_is_cr, w_is_tab;
    logic [MUL_W-1:0]           w_px, w_py;

    // Registers in use, saturated to the supported range.
    always_comb begin
        if (r_columns == '0) begin
            w_eff_cols = tcc_pkg::COLS_W'(1);
        end else if (r_columns > tcc_pkg::COLS_W'(MAX_COLUMNS)) begin
            w_eff_cols = tcc_pkg::COLS_W'(MAX_COLUMNS);
        end else begin
            w_eff_cols = r_columns;
        end
        if (r_rows == '0) begin
            w_eff_rows = tcc_pkg::ROWS_W'(1);
        end else if (r_rows > tcc_pkg::ROWS_W'(MAX_ROWS)) begin
            w_eff_rows = tcc_pkg::ROWS_W'(MAX_ROWS);
        end else begin
            w_eff_rows = r_rows;
        end
    end

    // Character decode.
    assign w_is_lf  = (i_char_code == tcc_pkg::CH_LF);
    assign w_is_cr  = (i_char_code == tcc_pkg::CH_CR);
    assign w_is_tab = (i_char_code == tcc_pkg::CH_TAB);

    // Cursor advance with wrap; the phase tracks the column modulo the tab stop.
    assign w_col_inc = {1'b0, r_col} + tcc_pkg::COLS_W'(1);
    assign w_wrap    = (w_col_inc >= w_eff_cols);
    assign w_row_up  = {1'b0, r_row} + tcc_pkg::ROWS_W'(1);
    assign w_ph_inc  = (r_phase == PH_W'(TAB_STOP - 1)) ? '0 : r_phase + PH_W'(1);

    // Glyph origin of the cursor cell.
    assign w_px = MUL_W'(r_col) * MUL_W'(CELL_WIDTH) + MUL_W'(BORDER);
    assign w_py = MUL_W'(r_row) * MUL_W'(CELL_HEIGHT) + MUL_W'(BORDER);

    // Next cursor and the word emitted by this step.
    always_comb begin
        n_col           = r_col;
        n_row           = {1'b0, r_row};
        n_phase         = r_phase;
        n_res.kind      = tcc_pkg::KIND_DRAW;
        n_res.cell_row  = r_row;
        n_res.cell_col  = r_col;
        n_res.cell_char = i_char_code;
        n_res.last      = i_cmd.last;
        case (i_cmd.op)
            tcc_pkg::OP_INPUT: begin
                if (w_is_lf) begin
                    n_res.kind = tcc_pkg::KIND_STORE;
                    n_col      = '0;
                    n_row      = w_row_up;
                    n_phase    = '0;
                end else if (w_is_cr) begin
                    n_res.kind = tcc_pkg::KIND_STORE;
                    n_col      = '0;
                    n_phase    = '0;
                end else if (w_is_tab) begin
                    n_res.kind = tcc_pkg::KIND_STORE;
                end else begin
                    n_col   = w_wrap ? '0 : w_col_inc[tcc_pkg::COL_W-1:0];
                    n_row   = w_wrap ? w_row_up : {1'b0, r_row};
                    n_phase = w_wrap ? '0 : w_ph_inc;
                end
            end
            tcc_pkg::OP_SPACE: begin
                n_res.cell_char = tcc_pkg::CH_SPACE;
                n_col   = w_wrap ? '0 : w_col_inc[tcc_pkg::COL_W-1:0];
                n_row   = w_wrap ? w_row_up : {1'b0, r_row};
                n_phase = w_wrap ? '0 : w_ph_inc;
            end
            tcc_pkg::OP_SCROLL: begin
                n_res.kind      = tcc_pkg::KIND_SCROLL;
                n_res.cell_row  = '0;
                n_res.cell_col  = '0;
                n_res.cell_char = '0;
                n_row           = w_eff_rows - tcc_pkg::ROWS_W'(1);
            end
            default: begin
                n_res.kind = tcc_pkg::KIND_SCROLL;
            end
        endcase
        n_res.pixel_x = (n_res.kind == tcc_pkg::KIND_DRAW) ? w_px[tcc_pkg::PX_W-1:0] : '0;
        n_res.pixel_y = (n_res.kind == tcc_pkg::KIND_DRAW) ? w_py[tcc_pkg::PY_W-1:0] : '0;
    end

    // Status back to the controller.
    assign o_sts.is_tab      = (i_cmd.op == tcc_pkg::OP_INPUT) && w_is_tab;
    assign o_sts.need_scroll = !o_sts.is_tab && (n_row >= w_eff_rows);
    assign o_sts.tab_cont    = (n_phase != '0);

    assign o_result = r_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= tcc_pkg::COLS_W'(256);
            r_rows    <= tcc_pkg::ROWS_W'(512);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tcc_pkg::CFG_COLUMNS: r_columns <= i_cfg_data[tcc_pkg::COLS_W-1:0];
                tcc_pkg::CFG_ROWS:    r_rows    <= i_cfg_data[tcc_pkg::ROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cursor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_cmd.step) begin
            r_col   <= n_col;
            r_row   <= n_row[tcc_pkg::ROW_W-1:0];
            r_phase <= n_phase;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ----- verif/cursor_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the text console cursor controller: predicts and compares output words.
module cursor_result_checker
    import tcc_pkg::*;
#(
    parameter int CELL_WIDTH  = 8,
    parameter int CELL_HEIGHT = 16,
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 512,
    parameter int TAB_STOP    = 4,
    parameter int BORDER      = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    tcc_char_if                    i_char,
    tcc_result_if                  i_res,
    output int                     o_fail_count,
    output int                     o_pending
);

    // Screen size registers as written, and the cursor as the block should hold it.
    logic [COLS_W-1:0] columns_reg;
    logic [ROWS_W-1:0] rows_reg;
    int                cur_col;
    int                cur_row;

    // Output words still owed by the block, oldest first.
    t_result           word_q[$];
    int                mism_count = 0;

    // Register values outside the usable range are clamped; zero acts as one.
    function automatic int screen_cols();
        if (columns_reg == '0) return 1;
        if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(columns_reg);
    endfunction

    function automatic int screen_rows();
        if (rows_reg == '0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    // Pixel origins are only filled in for glyph draws.
    task automatic queue_word(input logic [1:0] kind, input int row, input int col,
                              input logic [7:0] code);
        t_result w;
        w           = '0;
        w.kind      = kind;
        w.cell_row  = row[ROW_W-1:0];
        w.cell_col  = col[COL_W-1:0];
        w.cell_char = code;
        if (kind == KIND_DRAW) begin
            w.pixel_x = PX_W'(col * CELL_WIDTH + BORDER);
            w.pixel_y = PY_W'(row * CELL_HEIGHT + BORDER);
        end
        word_q.push_back(w);
    endtask

    // A cursor at or below the row count scrolls once and lands on the last row.
    task automatic scroll_if_below();
        if (cur_row >= screen_rows()) begin
            queue_word(KIND_SCROLL, 0, 0, 8'h00);
            cur_row = screen_rows() - 1;
        end
    endtask

    task automatic draw_and_advance(input logic [7:0] code);
        queue_word(KIND_DRAW, cur_row, cur_col, code);
        cur_col++;
        if (cur_col >= screen_cols()) begin
            cur_col = 0;
            cur_row++;
        end
        scroll_if_below();
    endtask

    // Work out every word that one accepted character causes.
    task automatic predict_char(input logic [7:0] code);
        int      spaces;
        t_result tail;
        case (code)
            CH_LF: begin
                queue_word(KIND_STORE, cur_row, cur_col, code);
                cur_col = 0;
                cur_row++;
                scroll_if_below();
            end
            CH_CR: begin
                queue_word(KIND_STORE, cur_row, cur_col, code);
                cur_col = 0;
                scroll_if_below();
            end
            CH_TAB: begin
                // Marker first, then spaces up to the next tab stop or a wrap.
                queue_word(KIND_STORE, cur_row, cur_col, code);
                spaces = 0;
                do begin
                    draw_and_advance(CH_SPACE);
                    spaces++;
                end while ((cur_col % TAB_STOP) != 0 && spaces < TAB_STOP);
                scroll_if_below();
            end
            default: begin
                draw_and_advance(code);
            end
        endcase
        tail      = word_q.pop_back();
        tail.last = 1'b1;
        word_q.push_back(tail);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mism_count++;
        end
    endtask

    // Inputs are predicted before outputs are compared in the same cycle.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            columns_reg = 9'd256;
            rows_reg    = 10'd512;
            cur_col     = 0;
            cur_row     = 0;
            word_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_COLUMNS: columns_reg = i_cfg_data[COLS_W-1:0];
                    CFG_ROWS:    rows_reg    = i_cfg_data[ROWS_W-1:0];
                    default:     ;
                endcase
            end
            if (i_char.valid && i_char.ready) begin
                predict_char(i_char.char_code);
            end
            if (i_res.valid && i_res.ready) begin
                if (word_q.size() == 0) begin
                    $error("Result word arrived with nothing expected (kind %0d, char %0d)",
                           i_res.kind, i_res.cell_char);
                    mism_count++;
                end else begin
                    want = word_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_res.kind));
                    check_field("cell_row", 32'(want.cell_row), 32'(i_res.cell_row));
                    check_field("cell_col", 32'(want.cell_col), 32'(i_res.cell_col));
                    check_field("cell_char", 32'(want.cell_char), 32'(i_res.cell_char));
                    check_field("pixel_x", 32'(want.pixel_x), 32'(i_res.pixel_x));
                    check_field("pixel_y", 32'(want.pixel_y), 32'(i_res.pixel_y));
                    check_field("last", 32'(want.last), 32'(i_res.last));
                end
            end
        end
        o_pending    <= word_q.size();
        o_fail_count <= mism_count;
    end

endmodule

// ----- verif/text_console_cursor_control_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the text console cursor controller: stimulus, pacing and verdict.
module text_console_cursor_control_test;
    import tcc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int LONG_HOLD    = 150;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    // Pacing controls: quiet is shared by the sender and the receiver; the hold counts pace the receiver.
    bit                    quiet        = 1'b0;
    int                    holds_wanted = 0;
    int                    holds_done   = 0;

    tcc_char_if   char_bus ();
    tcc_result_if res_bus ();

    text_console_cursor_control dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_char      (char_bus),
        .o_res       (res_bus)
    );

    cursor_result_checker u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_char       (char_bus),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly well-formed text with tabs, line controls and some arbitrary bytes.
    function automatic logic [7:0] pick_char(input int tab_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < tab_pct) return CH_TAB;
        if (roll < tab_pct + 10) return CH_LF;
        if (roll < tab_pct + 16) return CH_CR;
        if (roll < tab_pct + 30) return 8'($urandom);
        return 8'($urandom_range(33, 126));
    endfunction

    // Offer one character, maybe after an idle burst, and return at its acceptance edge.
    task automatic send_char(input logic [7:0] code);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        @(posedge clk);
        while (!char_bus.ready) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted word has come out.
    task automatic drain_results();
        char_bus.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Both screen registers are written on consecutive cycles while the block is idle.
    task automatic set_screen(input logic [CFG_DATA_W-1:0] cols_val,
                              input logic [CFG_DATA_W-1:0] rows_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COLUMNS;
        cfg_data  <= cols_val;
        @(posedge clk);
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows_val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] cols_val,
                             input logic [CFG_DATA_W-1:0] rows_val,
                             input int count, input int tab_pct);
        set_screen(cols_val, rows_val);
        repeat (count) send_char(pick_char(tab_pct));
        drain_results();
    endtask

    // Receiver: ready stretches, short stalls, and a long hold-off when asked.
    initial begin : result_pacing
        res_bus.ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (holds_done < holds_wanted) begin
                holds_done++;
                res_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end else begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Give up on a hung run.
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] opening[10];
        logic [7:0] shrunk[4];
        logic [7:0] tiny[3];
        logic [7:0] clamped[5];

        opening = '{8'h41, 8'h00, 8'hFF, CH_CR, 8'h31,
                    CH_TAB, CH_TAB, CH_LF, 8'h80, 8'h7F};
        shrunk  = '{8'h5A, CH_TAB, CH_LF, CH_CR};
        tiny    = '{CH_SPACE, CH_TAB, CH_LF};
        clamped = '{8'h55, 8'hAA, CH_TAB, 8'h0F, 8'hF0};

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_COLUMNS;
        cfg_data           = '0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset screen size: plain bytes at both ends, line controls and tabs
        // from an odd column and from a tab stop.
        foreach (opening[k]) send_char(opening[k]);
        drain_results();

        // Screen shrunk under the cursor: wraps and scrolls from outside the screen.
        set_screen(10'd2, 10'd1);
        foreach (shrunk[k]) send_char(shrunk[k]);
        drain_results();

        // Zero sizes behave as a single cell.
        set_screen(10'd0, 10'd0);
        foreach (tiny[k]) send_char(tiny[k]);
        drain_results();

        // Oversized register values clamp to the largest screen.
        set_screen(10'h3FF, 10'h3FF);
        foreach (clamped[k]) send_char(clamped[k]);
        drain_results();

        // Random text on a range of screen sizes.
        run_phase(10'd20, 10'd6, 40, 20);
        holds_wanted++;
        run_phase(10'($urandom_range(1, 8)), 10'($urandom_range(1, 4)), 40, 25);
        run_phase(10'($urandom), 10'($urandom), 40, 15);
        run_phase(10'd256, 10'd1, 40, 15);
        // One column per row: every printable character and newline steps the cursor down a row on a tall screen.
        run_phase(10'd1, 10'd512, 30, 5);
        quiet = 1'b1;
        run_phase(10'd3, 10'd2, 40, 30);

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
